// File: hdl/msk9_pkg.sv
// Shared types and constants for the masked nine-point relaxation sweep.
`timescale 1ns / 1ps
`default_nettype none
package msk9_pkg;

  localparam int unsigned POT_W      = 32;
  localparam int unsigned CELL_W     = POT_W + 1;  // potential plus fixed flag
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned THR_W      = 63;
  localparam int unsigned SIZE_CFG_W = 9;
  localparam int unsigned CFG_DATA_W = 63;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned SUM_W      = 64;
  // divide by 12*4096 = 3 << 14
  localparam int unsigned DIV_SHIFT  = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_GAIN = 2'd2,
    REG_THR  = 2'd3
  } cfg_reg_t;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic signed [POT_W-1:0] potential;
    logic                    is_fixed;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]      cell_row;
    logic [COORD_W-1:0]      cell_col;
    logic signed [POT_W-1:0] new_potential;
    logic                    end_of_frame;
    logic                    converged;
  } out_item_t;

endpackage
`default_nettype wire

// File: hdl/msk9_line_mem.sv
// Line store: one entry per column holding the two previous rows' cells.
`timescale 1ns / 1ps
`default_nettype none
module msk9_line_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic                            clk,
  input  wire logic                            we,
  input  wire logic [AW-1:0]                   waddr,
  input  wire logic [2*msk9_pkg::CELL_W-1:0]   wdata,
  input  wire logic                            re,
  input  wire logic [AW-1:0]                   raddr,
  output logic      [2*msk9_pkg::CELL_W-1:0]   rdata
);
  import msk9_pkg::*;

  logic [2*CELL_W-1:0] mem [DEPTH];

  // synchronous write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/msk9_relax_unit.sv
// Multi-cycle over-relaxed update of one cell and its squared change.
`timescale 1ns / 1ps
`default_nettype none
module msk9_relax_unit (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  input  wire logic [8:0][msk9_pkg::POT_W-1:0]         win,
  input  wire logic [msk9_pkg::GAIN_W-1:0]             gain,
  output logic                                         done,
  output logic signed [msk9_pkg::POT_W-1:0]            new_pot,
  output logic [msk9_pkg::SUM_W-1:0]                   sq_change
);
  import msk9_pkg::*;

  localparam int unsigned DW = 38;                 // stencil difference
  localparam int unsigned PW = GAIN_W + 1 + DW;    // gain times difference
  localparam int unsigned QW = 40;                 // quotient magnitude
  localparam int unsigned SW = 42;                 // phi plus change
  localparam int unsigned NSTEP = QW / 8;

  typedef enum logic [2:0] {
    R_IDLE, R_MUL, R_ABS, R_DIV, R_ADD, R_SQ
  } rstate_t;

  rstate_t                 state_r;
  logic signed [DW-1:0]    d_r;
  logic signed [POT_W-1:0] phi_r;
  logic [GAIN_W-1:0]       gain_r;
  logic signed [PW-1:0]    prod_r;
  logic                    neg_r;
  logic [QW-1:0]           num_r;
  logic [QW-1:0]           quo_r;
  logic [1:0]              rem_r;
  logic [2:0]              cnt_r;
  logic signed [POT_W-1:0] nv_r;
  logic [SUM_W-1:0]        sq_r;
  logic                    done_r;

  // stencil difference 2*edges + corners - 12*phi
  logic signed [DW-1:0] w_x [9];
  logic signed [DW-1:0] edges, corners, d_nxt;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      w_x[i] = {{(DW-POT_W){win[i][POT_W-1]}}, win[i]};
    end
    edges   = w_x[1] + w_x[7] + w_x[3] + w_x[5];
    corners = w_x[0] + w_x[2] + w_x[6] + w_x[8];
    d_nxt   = (edges <<< 1) + corners - (w_x[4] <<< 3) - (w_x[4] <<< 2);
  end

  // magnitude of the product, before the shift by 2^14
  logic [PW-1:0] mag;
  always_comb begin
    mag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
  end

  // eight radix-2 steps of divide by three per cycle
  logic [1:0] rem_nxt;
  logic [7:0] qbits;
  logic [2:0] t;
  always_comb begin
    rem_nxt = rem_r;
    qbits   = '0;
    t       = '0;
    for (int k = 0; k < 8; k++) begin
      t = {rem_nxt, num_r[QW-1-k]};
      if (t >= 3'd3) begin
        qbits[7-k] = 1'b1;
        rem_nxt    = 2'(t - 3'd3);
      end else begin
        rem_nxt    = t[1:0];
      end
    end
  end

  // truncated change added to phi, then saturated
  logic signed [SW-1:0] chg, sum_v;
  logic signed [POT_W-1:0] nv_nxt;
  always_comb begin
    chg   = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
    sum_v = {{(SW-POT_W){phi_r[POT_W-1]}}, phi_r} + chg;
    if (sum_v > SW'(64'sh7FFFFFFF)) begin
      nv_nxt = 32'sh7FFFFFFF;
    end else if (sum_v < -SW'(64'sh80000000)) begin
      nv_nxt = 32'sh80000000;
    end else begin
      nv_nxt = sum_v[POT_W-1:0];
    end
  end

  // squared change of the saturated result
  logic signed [POT_W:0] diff;
  logic [POT_W-1:0]      dmag;
  always_comb begin
    diff = {nv_r[POT_W-1], nv_r} - {phi_r[POT_W-1], phi_r};
    dmag = diff[POT_W] ? POT_W'(-diff) : POT_W'(diff);
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        R_IDLE: begin
          if (start) begin
            d_r     <= d_nxt;
            phi_r   <= win[4];
            gain_r  <= gain;
            state_r <= R_MUL;
          end
        end
        R_MUL: begin
          prod_r  <= $signed({1'b0, gain_r}) * d_r;
          state_r <= R_ABS;
        end
        R_ABS: begin
          neg_r   <= prod_r[PW-1];
          num_r   <= mag[DIV_SHIFT +: QW];
          quo_r   <= '0;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= R_DIV;
        end
        R_DIV: begin
          num_r <= num_r << 8;
          quo_r <= {quo_r[QW-9:0], qbits};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'(NSTEP - 1)) begin
            state_r <= R_ADD;
          end
        end
        R_ADD: begin
          nv_r    <= nv_nxt;
          state_r <= R_SQ;
        end
        R_SQ: begin
          sq_r    <= SUM_W'(dmag) * SUM_W'(dmag);
          done_r  <= 1'b1;
          state_r <= R_IDLE;
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign done      = done_r;
  assign new_pot   = nv_r;
  assign sq_change = sq_r;

endmodule
`default_nettype wire

// File: hdl/masked_nine_point_relaxation_sweep_core.sv
// Top level of the masked nine-point relaxation sweep core.
// Cells enter in raster order, one item at a time: a new cell is taken only
// when the last one is through. A cell is accepted, its line store read
// follows, then it releases its results (zero to three) one by one and returns
// to idle; a cell that releases a free interior cell first runs the relaxation
// unit, whose serial divide by three runs eight quotient bits a cycle. Results
// wait while out_ready is held low. The line store is one single-port-read
// memory of MAX_GRID entries, each holding the two earlier rows of that column;
// it has no clearing pass after reset. The change sum clears at the first
// cell of each frame, and converged is raised with end_of_frame when the sum
// lies below the REG_THR threshold.
`timescale 1ns / 1ps
`default_nettype none
module masked_nine_point_relaxation_sweep_core #(
  parameter int unsigned MAX_GRID = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire msk9_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output msk9_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [msk9_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [msk9_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import msk9_pkg::*;

  localparam int unsigned CW = $clog2(MAX_GRID);
  localparam int unsigned SW = $clog2(MAX_GRID + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_START, S_CALC, S_EMIT
  } state_t;

  state_t                state_r;
  logic [SIZE_CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [THR_W-1:0]      thr_r;
  logic [CW-1:0]         row_cnt_r, col_cnt_r;
  logic [CW-1:0]         cur_row_r, cur_col_r;
  cell_t                 cell_r;
  cell_t [8:0]           win_r;
  logic [2:0]            pend_r;
  logic                  eof_r;
  logic signed [POT_W-1:0] val0_r, val1_r, val2_r;
  logic [SUM_W-1:0]      change_sum_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= SIZE_CFG_W'(256);
      cols_cfg_r <= SIZE_CFG_W'(256);
      gain_r     <= GAIN_W'(6144);
      thr_r      <= THR_W'(42949673);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROWS: rows_cfg_r <= cfg_wdata[SIZE_CFG_W-1:0];
        REG_COLS: cols_cfg_r <= cfg_wdata[SIZE_CFG_W-1:0];
        REG_GAIN: gain_r     <= cfg_wdata[GAIN_W-1:0];
        REG_THR:  thr_r      <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective grid size, clamped into [3, MAX_GRID]
  logic [SW-1:0] nr, nc;
  always_comb begin
    if (rows_cfg_r < SIZE_CFG_W'(3)) begin
      nr = SW'(3);
    end else if (32'(rows_cfg_r) > MAX_GRID) begin
      nr = SW'(MAX_GRID);
    end else begin
      nr = SW'(rows_cfg_r);
    end
    if (cols_cfg_r < SIZE_CFG_W'(3)) begin
      nc = SW'(3);
    end else if (32'(cols_cfg_r) > MAX_GRID) begin
      nc = SW'(MAX_GRID);
    end else begin
      nc = SW'(cols_cfg_r);
    end
  end

  // position of the arriving cell and the counters after it
  logic          in_acc;
  logic [CW-1:0] r_now, c_now, row_nxt, col_nxt;
  logic [SW-1:0] c_inc, r_inc;
  always_comb begin
    in_acc  = in_valid && in_ready;
    r_now   = (SW'(row_cnt_r) >= nr) ? '0 : row_cnt_r;
    c_now   = (SW'(col_cnt_r) >= nc) ? '0 : col_cnt_r;
    c_inc   = SW'(c_now) + SW'(1);
    r_inc   = SW'(r_now) + SW'(1);
    col_nxt = c_inc[CW-1:0];
    row_nxt = r_now;
    if (c_inc >= nc) begin
      col_nxt = '0;
      row_nxt = (r_inc >= nr) ? '0 : r_inc[CW-1:0];
    end
  end

  // line store: read at accept, written back in the read-data cycle
  logic [2*CELL_W-1:0] mem_rdata;
  cell_t               up1, up2;
  logic                mem_we;
  assign up2    = mem_rdata[2*CELL_W-1:CELL_W];
  assign up1    = mem_rdata[CELL_W-1:0];
  assign mem_we = (state_r == S_READ);

  msk9_line_mem #(
    .DEPTH (MAX_GRID),
    .AW    (CW)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_col_r),
    .wdata ({up1, cell_r}),
    .re    (in_acc),
    .raddr (c_now),
    .rdata (mem_rdata)
  );

  // relaxation unit on the centre of the window
  logic [8:0][POT_W-1:0]   win_pot;
  logic                    relax_done;
  logic signed [POT_W-1:0] relax_pot;
  logic [SUM_W-1:0]        relax_sq;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      win_pot[i] = win_r[i][POT_W-1:0];
    end
  end

  msk9_relax_unit u_relax (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == S_START),
    .win       (win_pot),
    .gain      (gain_r),
    .done      (relax_done),
    .new_pot   (relax_pot),
    .sq_change (relax_sq)
  );

  // saturating accumulation of squared change
  logic [SUM_W:0] sum_ext;
  assign sum_ext = {1'b0, change_sum_r} + {1'b0, relax_sq};

  // release order: lowest pending bit first
  logic      out_load;
  logic [1:0] sel;
  out_item_t res;
  always_comb begin
    out_load = (state_r == S_EMIT) && (pend_r != 3'b000) &&
               (!out_valid_r || out_ready);
    sel      = pend_r[0] ? 2'd0 : (pend_r[1] ? 2'd1 : 2'd2);
    res      = '0;
    case (sel)
      2'd0: begin
        res.cell_row      = COORD_W'(cur_row_r - CW'(1));
        res.cell_col      = COORD_W'(cur_col_r - CW'(1));
        res.new_potential = val0_r;
      end
      2'd1: begin
        res.cell_row      = COORD_W'(cur_row_r - CW'(1));
        res.cell_col      = COORD_W'(cur_col_r);
        res.new_potential = val1_r;
      end
      default: begin
        res.cell_row      = COORD_W'(cur_row_r);
        res.cell_col      = COORD_W'(cur_col_r);
        res.new_potential = val2_r;
        res.end_of_frame  = eof_r;
        res.converged     = eof_r && (change_sum_r < {1'b0, thr_r});
      end
    endcase
  end

  // window after this cell's shift
  cell_t [8:0] win_nxt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[3*i]   = win_r[3*i+1];
      win_nxt[3*i+1] = win_r[3*i+2];
    end
    win_nxt[2] = up2;
    win_nxt[5] = up1;
    win_nxt[8] = cell_r;
  end

  // sequencer, counters, window and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_cnt_r    <= '0;
      col_cnt_r    <= '0;
      win_r        <= '0;
      change_sum_r <= '0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cur_row_r <= r_now;
            cur_col_r <= c_now;
            cell_r    <= {in_data.is_fixed, in_data.potential};
            row_cnt_r <= row_nxt;
            col_cnt_r <= col_nxt;
            if (r_now == '0 && c_now == '0) begin
              change_sum_r <= '0;
            end
            state_r <= S_READ;
          end
        end
        S_READ: begin
          win_r  <= win_nxt;
          val0_r <= win_nxt[4][POT_W-1:0];
          val1_r <= up1[POT_W-1:0];
          val2_r <= cell_r[POT_W-1:0];
          eof_r  <= (SW'(cur_col_r) + SW'(1) == nc);
          pend_r[0] <= (cur_row_r >= CW'(1)) && (cur_col_r >= CW'(1));
          pend_r[1] <= (cur_row_r >= CW'(1)) && (SW'(cur_col_r) + SW'(1) == nc);
          pend_r[2] <= (SW'(cur_row_r) + SW'(1) == nr);
          if (cur_row_r >= CW'(2) && cur_col_r >= CW'(2) && !win_nxt[4][POT_W]) begin
            state_r <= S_START;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_START: state_r <= S_CALC;
        S_CALC: begin
          if (relax_done) begin
            val0_r       <= relax_pot;
            change_sum_r <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            state_r      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pend_r == 3'b000) begin
            state_r <= S_IDLE;
          end else if (out_load) begin
            out_valid_r <= 1'b1;
            out_data_r  <= res;
            pend_r[sel] <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an accepted cell always goes on to its line store read
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_READ))
    else $error("accepted cell did not move to the read cycle");

  // the relaxation unit only finishes while the sequencer waits for it
  a_done_calc: assert property (@(posedge clk) disable iff (!rst_n)
    relax_done |-> (state_r == S_CALC))
    else $error("relaxation result outside the wait state");

  // convergence is reported only on the frame's last cell
  a_conv_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.converged) |-> out_data.end_of_frame)
    else $error("converged raised without end of frame");

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the masked nine-point relaxation sweep core.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import msk9_pkg::*;

  localparam int unsigned GRID_MAX   = 256;
  localparam int unsigned STALL_MAX  = 5000;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned SETTLE_CYC = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  masked_nine_point_relaxation_sweep_core #(.MAX_GRID(GRID_MAX)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // effective grid size after clamping
  function automatic int unsigned grid_size(logic [SIZE_CFG_W-1:0] v);
    if (v < 3) return 3;
    if (v > GRID_MAX) return GRID_MAX;
    return 32'(v);
  endfunction

  // Predicts the sweep output stream and checks the core against it
  class sweep_scoreboard;
    logic [SIZE_CFG_W-1:0] rows_reg;
    logic [SIZE_CFG_W-1:0] cols_reg;
    logic [GAIN_W-1:0]     gain_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [CELL_W-1:0]     lines [2*GRID_MAX];
    logic [CELL_W-1:0]     win [3][3];
    int unsigned           row_pos;
    int unsigned           col_pos;
    logic [SUM_W-1:0]      sq_sum;
    out_item_t             expected_q[$];
    int unsigned           errors;

    function new();
      rows_reg = 256;
      cols_reg = 256;
      gain_reg = 6144;
      thr_reg  = 63'd42949673;
      foreach (lines[i]) lines[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      row_pos = 0;
      col_pos = 0;
      sq_sum  = '0;
      errors  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_ROWS: rows_reg = v[SIZE_CFG_W-1:0];
        REG_COLS: cols_reg = v[SIZE_CFG_W-1:0];
        REG_GAIN: gain_reg = v[GAIN_W-1:0];
        REG_THR:  thr_reg  = v[THR_W-1:0];
      endcase
    endfunction

    function longint pot(logic [CELL_W-1:0] c);
      logic signed [POT_W-1:0] p;
      p = c[POT_W-1:0];
      return p;
    endfunction

    // over-relaxed update of the window centre, accumulating squared change
    function longint relaxed_centre();
      longint phi, edges, corners, diff, delta, nv;
      logic [SUM_W-1:0] mag, sq;
      phi     = pot(win[1][1]);
      edges   = pot(win[0][1]) + pot(win[2][1]) + pot(win[1][0]) + pot(win[1][2]);
      corners = pot(win[0][0]) + pot(win[0][2]) + pot(win[2][0]) + pot(win[2][2]);
      diff    = 2 * edges + corners - 12 * phi;
      delta   = (longint'(gain_reg) * diff) / 49152;
      nv      = phi + delta;
      if (nv > 64'sd2147483647) nv = 64'sd2147483647;
      if (nv < -64'sd2147483648) nv = -64'sd2147483648;
      mag = (nv >= phi) ? nv - phi : phi - nv;
      sq  = mag * mag;
      sq_sum = (sq_sum > ~sq) ? '1 : sq_sum + sq;
      return nv;
    endfunction

    function void push(int unsigned r, int unsigned c, longint v, bit eof, bit conv);
      out_item_t e;
      e.cell_row      = r[COORD_W-1:0];
      e.cell_col      = c[COORD_W-1:0];
      e.new_potential = v[POT_W-1:0];
      e.end_of_frame  = eof;
      e.converged     = conv;
      expected_q.push_back(e);
    endfunction

    // accepted input item: shift the window and queue what it releases
    function void note_input(in_item_t it);
      int unsigned nr, nc, r, c;
      logic [CELL_W-1:0] cur_cell, up1, up2;
      longint v;
      bit eof;
      nr   = grid_size(rows_reg);
      nc   = grid_size(cols_reg);
      cur_cell = {it.is_fixed, it.potential};
      if (col_pos >= nc) col_pos = 0;
      if (row_pos >= nr) row_pos = 0;
      r = row_pos;
      c = col_pos;
      if (r == 0 && c == 0) sq_sum = '0;
      up1 = lines[c];
      up2 = lines[GRID_MAX + c];
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = cur_cell;
      lines[GRID_MAX + c] = up1;
      lines[c] = cur_cell;
      if (r >= 1 && c >= 1) begin
        if (r >= 2 && c >= 2 && !win[1][1][POT_W]) v = relaxed_centre();
        else v = pot(win[1][1]);
        push(r - 1, c - 1, v, 1'b0, 1'b0);
      end
      if (r >= 1 && c == nc - 1) push(r - 1, c, pot(win[1][2]), 1'b0, 1'b0);
      if (r == nr - 1) begin
        eof = (c == nc - 1);
        push(r, c, pot(cur_cell), eof, eof && (sq_sum < {1'b0, thr_reg}));
      end
      col_pos = c + 1;
      if (col_pos >= nc) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= nr) row_pos = 0;
      end
    endfunction

    function void check(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: row %0d col %0d pot %0d",
                                   got.cell_row, got.cell_col, got.new_potential);
        return;
      end
      e = expected_q.pop_front();
      if (got.cell_row !== e.cell_row || got.cell_col !== e.cell_col ||
          got.new_potential !== e.new_potential || got.end_of_frame !== e.end_of_frame ||
          got.converged !== e.converged) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp r%0d c%0d pot %0d eof %0b conv %0b / got r%0d c%0d pot %0d eof %0b conv %0b",
                   e.cell_row, e.cell_col, e.new_potential, e.end_of_frame, e.converged,
                   got.cell_row, got.cell_col, got.new_potential, got.end_of_frame,
                   got.converged);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  sweep_scoreboard sb = new();

  int unsigned tx_idle;
  int unsigned rx_idle;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_cnt;
  int unsigned sent;
  int unsigned n_rows;
  int unsigned n_cols;

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // receiver: random back-pressure plus the occasional long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_MAX) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every expected item, then let the core settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic configure(logic [SIZE_CFG_W-1:0] rv, logic [SIZE_CFG_W-1:0] cv,
                           logic [GAIN_W-1:0] g, logic [THR_W-1:0] t);
    write_reg(REG_ROWS, CFG_DATA_W'(rv));
    write_reg(REG_COLS, CFG_DATA_W'(cv));
    write_reg(REG_GAIN, CFG_DATA_W'(g));
    write_reg(REG_THR, CFG_DATA_W'(t));
    n_rows = grid_size(rv);
    n_cols = grid_size(cv);
  endtask

  task automatic send_cell(in_item_t it);
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  function automatic in_item_t make_cell(int unsigned style, int unsigned fix_pct);
    in_item_t it;
    case (style)
      0: it.potential = $urandom;
      1: it.potential = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default:
        case ($urandom_range(3))
          0: it.potential = 32'h7fff_ffff;
          1: it.potential = 32'h8000_0000;
          2: it.potential = '0;
          default: it.potential = '1;
        endcase
    endcase
    it.is_fixed = ($urandom_range(99) < fix_pct);
    return it;
  endfunction

  task automatic random_frame(int unsigned style, int unsigned fix_pct);
    for (int unsigned k = 0; k < n_rows * n_cols; k++) send_cell(make_cell(style, fix_pct));
    in_valid <= 1'b0;
    drain();
  endtask

  // 3x3 frame: all border cells set to edge_v, free centre set to mid_v
  task automatic directed_frame(logic [POT_W-1:0] edge_v, logic [POT_W-1:0] mid_v);
    in_item_t it;
    for (int unsigned k = 0; k < 9; k++) begin
      it.potential = (k == 4) ? mid_v : edge_v;
      it.is_fixed  = (k % 2 == 1);
      send_cell(it);
    end
    in_valid <= 1'b0;
    drain();
  endtask

  logic [THR_W-1:0] thr;

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    tx_idle   = 0;
    rx_idle   = 0;
    hold_req  = 1'b0;
    hold_left = 0;
    stall_cnt = 0;
    sent      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: both saturation directions, smallest grid, gain and threshold extremes
    configure(9'd2, 9'd0, 16'hffff, '0);
    directed_frame(32'h7fff_ffff, 32'h8000_0000);
    directed_frame(32'h8000_0000, 32'h7fff_ffff);
    configure(9'd3, 9'd3, 16'h0000, '1);
    directed_frame(32'h0001_0000, 32'hffff_0000);

    // random frames, mostly small grids; idling pattern changes at 100 and 180 cells sent
    while (sent < 250) begin
      if (sent < 100) begin
        tx_idle = 35;
        rx_idle = 82;
      end else if (sent < 180) begin
        tx_idle = 82;
        rx_idle = 35;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      case ($urandom_range(3))
        0: thr = '0;
        1: thr = '1;
        2: thr = THR_W'({$urandom, $urandom});
        default: thr = THR_W'($urandom_range(0, 32'h0800_0000));
      endcase
      configure(SIZE_CFG_W'($urandom_range(0, 9)), SIZE_CFG_W'($urandom_range(0, 11)),
                ($urandom_range(4) == 0) ? 16'hffff : 16'($urandom), thr);
      if (sent >= 180 && sent < 240) hold_req = 1'b1;
      random_frame($urandom_range(2), $urandom_range(0, 40));
    end

    // tall and wide frames
    tx_idle = 0;
    rx_idle = 0;
    configure(9'd30, 9'd3, 16'd6144, THR_W'({$urandom, $urandom}));
    random_frame(1, 20);
    configure(9'd3, 9'd30, 16'($urandom), '1);
    hold_req = 1'b1;
    random_frame(0, 20);

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hdl/msk9_pkg.sv
hdl/msk9_line_mem.sv
hdl/msk9_relax_unit.sv
hdl/masked_nine_point_relaxation_sweep_core.sv
tb/sv/tb.sv
